[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/dfcd_pkg.sv]
// Package of the dollar framed command decoder: sizes, character codes,
// command patterns and the types shared by the controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package dfcd_pkg;

  // Number of characters the frame text store holds.
  localparam int TEXT_CHARS = 19;
  localparam int LEN_W      = $clog2(TEXT_CHARS + 1);
  localparam int ADDR_W     = $clog2(TEXT_CHARS);

  // Only the first seven characters ever matter for a command.
  localparam int CMP_CHARS   = 7;
  localparam int IDX_W       = $clog2(CMP_CHARS);
  localparam int PARSE_FIRST = 4;

  localparam int LEN_MANUAL = 7;
  localparam int LEN_AUTO   = 5;
  localparam int LEN_PWM    = 4;

  localparam int DUTY_W = 11;
  localparam int ACC_W  = 10;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_MANUAL = 2'd1,
    EV_AUTO   = 2'd2,
    EV_DUTY   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PS_BLANK,
    PS_DIGIT,
    PS_STOP
  } parse_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic finish;
  } dfcd_cmd_t;

  typedef struct packed {
    logic is_close;
    logic rd_last;
  } dfcd_sts_t;

  function automatic logic [7:0] manual_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h6D;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h75;
      3'd5:    c = 8'h61;
      3'd6:    c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] auto_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h6F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pwm_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h57;
      3'd3:    c = 8'h4D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dollar_framed_command_decoder.sv]
// Top level of the dollar framed command decoder.
// Uses dfcd_pkg and instantiates dfcd_ctrl and dfcd_dp.
//
//   Channel   Direction  Handshake             Payload
//   in_       in         in_valid / in_ready   in_rx_byte (8 bits)
//   out_      out        out_valid / out_ready out_manual_mode, out_duty_cycle,
//                                              out_command_event
//
// A byte that does not close a frame loads its result into the output
// register as it is accepted. A closing '$' starts the evaluation: the
// READ state reads the first seven characters of the text store through
// its single read port, DRAIN lets the read register's last character be
// used, and DONE loads the result once the output register is free. The
// input is held off during that sequence until the controller is idle.
// Reset is synchronous and active low and needs no clearing pass; stored
// characters past the frame length are read but ignored. A new item is
// taken while the last result waits, as long as that result leaves the
// output register in the same cycle or the register is empty.
`timescale 1ns / 1ps
`default_nettype none

module dollar_framed_command_decoder import dfcd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               in_rx_byte,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_manual_mode,
  output logic signed [DUTY_W-1:0]      out_duty_cycle,
  output logic [1:0]                    out_command_event
);

  // Control and status between the sequencer and the datapath.
  dfcd_cmd_t cmd;
  dfcd_sts_t sts;
  event_t    event_code;

  // The controller owns the handshakes and steps through the evaluation
  // of a closed frame.
  dfcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the frame text, mode and duty, and the result
  // register that faces the output channel.
  dfcd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .manual_mode   (out_manual_mode),
    .duty_cycle    (out_duty_cycle),
    .command_event (event_code)
  );

  assign out_command_event = event_code;

endmodule

`default_nettype wire

[hw/rtl/dfcd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the frame text store.
`timescale 1ns / 1ps
`default_nettype none

module dfcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dfcd_ctrl.sv]
// Controller of the command decoder: handshakes and the evaluation sequence.
// Uses dfcd_pkg; drives the datapath by command struct, reads its status.
`timescale 1ns / 1ps
`default_nettype none

module dfcd_ctrl import dfcd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dfcd_sts_t sts,
  output dfcd_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && slot_free && sts.is_close) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        cmd.take = in_valid && slot_free;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A plain item loads the output at acceptance; a closing one at finish.
  always_comb begin
    if ((cmd.take && !sts.is_close) || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hw/rtl/dfcd_dp.sv]
// Datapath of the command decoder: frame state, text store, command
// matching, duty parsing and the output register. Uses dfcd_pkg, dfcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module dfcd_dp import dfcd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         rx_byte,
  input  wire dfcd_cmd_t          cmd,
  output dfcd_sts_t               sts,
  output logic                    manual_mode,
  output logic signed [DUTY_W-1:0] duty_cycle,
  output event_t                  command_event
);

  logic                     in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     mode_r, mode_nxt;
  logic signed [DUTY_W-1:0] duty_r, duty_nxt;

  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     proc_vld_r;
  logic [IDX_W-1:0]         proc_idx_r;
  logic                     mm_r, mm_nxt, ma_r, ma_nxt, mp_r, mp_nxt;
  parse_t                   ps_r, ps_nxt;
  logic                     neg_r, neg_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;

  logic                     out_mode_r, out_mode_nxt;
  logic signed [DUTY_W-1:0] out_duty_r, out_duty_nxt;
  event_t                   out_event_r, out_event_nxt;

  logic                     is_cr, is_dollar, close, frame_after;
  logic                     ram_we;
  logic [7:0]               ch;
  logic                     ch_used, ch_digit, ch_blank;
  logic [ACC_W+2:0]         acc_x10;
  logic                     hit_manual, hit_auto, hit_pwm;
  logic signed [DUTY_W-1:0] parsed;

  assign is_cr       = (rx_byte == CH_CR);
  assign is_dollar   = (rx_byte == CH_DOLLAR);
  assign close       = is_dollar && in_frame_r;
  assign frame_after = is_dollar ? !in_frame_r : in_frame_r;

  assign sts.is_close = close;
  assign sts.rd_last  = (rd_idx_r == IDX_W'(CMP_CHARS - 1));

  assign ram_we = cmd.take && !is_cr && !close && frame_after && (rx_byte != CH_NUL)
                  && (len_r < LEN_W'(TEXT_CHARS));

  dfcd_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_CHARS)
  ) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (ADDR_W'(rd_idx_r)),
    .rdata (ch)
  );

  assign ch_used  = proc_vld_r && (LEN_W'(proc_idx_r) < len_r);
  assign ch_digit = ch inside {[8'h30:8'h39]};
  assign ch_blank = (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});
  assign acc_x10  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0};

  assign hit_manual = mm_r && (len_r == LEN_W'(LEN_MANUAL));
  assign hit_auto   = ma_r && (len_r == LEN_W'(LEN_AUTO));
  assign hit_pwm    = mp_r && mode_r && (len_r >= LEN_W'(LEN_PWM));
  assign parsed     = neg_r ? (DUTY_W'(0) - {1'b0, acc_r}) : {1'b0, acc_r};

  // Frame bookkeeping and output loading.
  always_comb begin
    in_frame_nxt  = in_frame_r;
    len_nxt       = len_r;
    mode_nxt      = mode_r;
    duty_nxt      = duty_r;
    out_mode_nxt  = out_mode_r;
    out_duty_nxt  = out_duty_r;
    out_event_nxt = out_event_r;
    if (cmd.take && !is_cr) begin
      if (close) begin
        in_frame_nxt = 1'b0;
      end else begin
        in_frame_nxt = frame_after;
        if (ram_we) begin
          len_nxt = len_r + LEN_W'(1);
        end else if (!frame_after) begin
          len_nxt = '0;
        end
      end
    end
    if (cmd.take && !close) begin
      out_mode_nxt  = mode_r;
      out_duty_nxt  = duty_r;
      out_event_nxt = EV_NONE;
    end
    if (cmd.finish) begin
      len_nxt       = '0;
      out_event_nxt = EV_NONE;
      if (hit_manual) begin
        mode_nxt      = 1'b1;
        out_event_nxt = EV_MANUAL;
      end else if (hit_auto) begin
        mode_nxt      = 1'b0;
        out_event_nxt = EV_AUTO;
      end else if (hit_pwm) begin
        duty_nxt      = parsed;
        out_event_nxt = EV_DUTY;
      end
      out_mode_nxt = mode_nxt;
      out_duty_nxt = duty_nxt;
    end
  end

  // One stored character per cycle: pattern compare and the number scan.
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    mm_nxt     = mm_r;
    ma_nxt     = ma_r;
    mp_nxt     = mp_r;
    ps_nxt     = ps_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    if (cmd.take && close) begin
      rd_idx_nxt = '0;
      mm_nxt     = 1'b1;
      ma_nxt     = 1'b1;
      mp_nxt     = 1'b1;
      ps_nxt     = PS_BLANK;
      neg_nxt    = 1'b0;
      acc_nxt    = '0;
    end
    if (cmd.rd_en) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
    if (ch_used) begin
      mm_nxt = mm_r && (ch == manual_char(proc_idx_r));
      if (proc_idx_r < IDX_W'(LEN_AUTO)) begin
        ma_nxt = ma_r && (ch == auto_char(proc_idx_r));
      end
      if (proc_idx_r < IDX_W'(LEN_PWM)) begin
        mp_nxt = mp_r && (ch == pwm_char(proc_idx_r));
      end
      if (proc_idx_r >= IDX_W'(PARSE_FIRST)) begin
        case (ps_r)
          PS_BLANK: begin
            if (ch_blank) begin
              ps_nxt = PS_BLANK;
            end else if (ch == CH_PLUS || ch == CH_MINUS) begin
              neg_nxt = (ch == CH_MINUS);
              ps_nxt  = PS_DIGIT;
            end else if (ch_digit) begin
              acc_nxt = ACC_W'(ch - CH_ZERO);
              ps_nxt  = PS_DIGIT;
            end else begin
              ps_nxt = PS_STOP;
            end
          end
          PS_DIGIT: begin
            if (ch_digit) begin
              acc_nxt = ACC_W'(acc_x10 + {5'b00000, ch - CH_ZERO});
            end else begin
              ps_nxt = PS_STOP;
            end
          end
          default: begin
            ps_nxt = PS_STOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      len_r      <= '0;
      mode_r     <= 1'b0;
      duty_r     <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      len_r      <= len_nxt;
      mode_r     <= mode_nxt;
      duty_r     <= duty_nxt;
      proc_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    proc_idx_r  <= rd_idx_r;
    mm_r        <= mm_nxt;
    ma_r        <= ma_nxt;
    mp_r        <= mp_nxt;
    ps_r        <= ps_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    out_mode_r  <= out_mode_nxt;
    out_duty_r  <= out_duty_nxt;
    out_event_r <= out_event_nxt;
  end

  assign manual_mode   = out_mode_r;
  assign duty_cycle    = out_duty_r;
  assign command_event = out_event_r;

endmodule

`default_nettype wire

[hw/rtl/dfcd_checker.sv]
// Port-level checks of the dollar framed command decoder, bound to the top.
// Uses dfcd_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dfcd_checker import dfcd_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     out_manual_mode,
  input wire logic signed [DUTY_W-1:0] out_duty_cycle,
  input wire logic [1:0]               out_command_event
);

  // A stalled result keeps its event code.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_command_event))

  `ASSERT_IMPL(a_manual_mode, clk, rst_n, out_valid && out_command_event == EV_MANUAL, out_manual_mode)

  `ASSERT_IMPL(a_auto_mode, clk, rst_n, out_valid && out_command_event == EV_AUTO, !out_manual_mode)

  // A duty command is only obeyed in manual mode.
  `ASSERT_IMPL(a_duty_manual, clk, rst_n, out_valid && out_command_event == EV_DUTY, out_manual_mode)

  `ASSERT_IMPL(a_duty_range, clk, rst_n, out_valid, out_duty_cycle >= -11'sd99 && out_duty_cycle <= 11'sd999)

endmodule

bind dollar_framed_command_decoder dfcd_checker u_dfcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_manual_mode   (out_manual_mode),
  .out_duty_cycle    (out_duty_cycle),
  .out_command_event (out_command_event)
);

`default_nettype wire
